>>> rtl/phcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phcc_pkg;

  // shared divider: dividend and divisor widths
  localparam int DIV_N = 28;
  localparam int DIV_M = 16;

  // shared multiplier: signed a, unsigned b, signed product
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = 48;

  localparam int VOLT_W = 16;
  localparam int VREF_W = 13;
  localparam int SUM_W  = 22;
  localparam int CNT_W  = 6;
  localparam int PH_W   = 14;
  localparam int ACC_W  = 34;

  localparam logic [VREF_W-1:0] VREF_RESET = 13'd5000;

  // span of each segment in milli-pH, pre-shifted into Q16
  localparam logic [DIV_N-1:0] SPAN_LOW_Q16  = DIV_N'(2860 * 65536);
  localparam logic [DIV_N-1:0] SPAN_HIGH_Q16 = DIV_N'(2140 * 65536);

  localparam logic signed [MUL_A_W-1:0] PH_MID_MILLI = 32'sd6860;
  localparam logic signed [ACC_W-1:0]   PH_MAX_MILLI = 34'sd14000;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_M-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> rtl/phcc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module phcc_mul (
  input  wire                                   clk_i,
  input  wire  logic signed [phcc_pkg::MUL_A_W-1:0] a_i,
  input  wire  logic        [phcc_pkg::MUL_B_W-1:0] b_i,
  output logic signed [phcc_pkg::MUL_P_W-1:0]   prod_o
);
  import phcc_pkg::*;

  logic signed [MUL_P_W-1:0] prod_d;
  logic signed [MUL_P_W-1:0] prod_q;

  // b is always a magnitude, so widen it as a non-negative signed value
  assign prod_d = a_i * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> rtl/phcc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module phcc_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  phcc_pkg::div_req_t         req_i,
  output logic                             done_o,
  output logic [phcc_pkg::DIV_N-1:0]       quo_o
);
  import phcc_pkg::*;

  localparam int CW = $clog2(DIV_N);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_M-1:0]  rem_q, rem_d;
  logic [DIV_N-1:0]  quo_q, quo_d;
  logic [DIV_M-1:0]  dsr_q, dsr_d;
  logic [DIV_M:0]    rem_sh;
  logic [DIV_M+1:0]  diff;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[DIV_N-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = CW'(DIV_N - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DIV_M+1]) begin
        rem_d = diff[DIV_M-1:0];
        quo_d = {quo_q[DIV_N-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_M-1:0];
        quo_d = {quo_q[DIV_N-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> rtl/ph_three_point_calibrated_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-point pH converter. A calibration request carries a raw ADC code for
// buffer point 0 (pH 4), 1 (pH 6.86) or 2 (pH 9); codes are scaled by vref_mv
// and averaged over SAMPLES_PER_POINT requests, after which both line
// segments (slope in Q16 milli-pH per 0.1 mV, offset in milli-pH) are rebuilt.
// A convert request maps a voltage in 0.1 mV through the segment chosen
// against the pH 6.86 voltage and returns pH * 1000 clamped to 0..14000.
// One request is worked at a time on a shared multiplier and a shared
// 28-step serial divider. A convert request goes through the multiply, add
// and finish states (the add is skipped on an invalid segment); a calibration
// sample that does not finish a point goes through multiply, accumulate and
// finish; a sample that finishes a point adds up to three divider passes
// (average and two slopes) before the finish state. A calibration request
// for point selector 3 is ignored and answers zeros. The result sits in an
// output register, so the next request is taken while it waits. The user
// must write vref_mv through the cfg port only while the unit is idle; the
// unit itself does not enforce this.
module ph_three_point_calibrated_converter_unit #(
  parameter int ADC_BITS          = 12,
  parameter int SAMPLES_PER_POINT = 50
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [phcc_pkg::VREF_W-1:0]         cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 action_i,
  input  wire  [1:0]                          cal_point_i,
  input  wire  [ADC_BITS-1:0]                 adc_code_i,
  input  wire  [phcc_pkg::VOLT_W-1:0]         voltage_tenth_mv_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [phcc_pkg::PH_W-1:0]           ph_milli_o,
  output logic                                segment_used_o,
  output logic                                cal_point_done_o,
  output logic                                divide_error_o
);
  import phcc_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CAL_MUL = 4'd1;
  localparam logic [3:0] ST_CAL_ACC = 4'd2;
  localparam logic [3:0] ST_AVG_DIV = 4'd3;
  localparam logic [3:0] ST_SEG_BEG = 4'd4;
  localparam logic [3:0] ST_SEG_DIV = 4'd5;
  localparam logic [3:0] ST_SEG_MUL = 4'd6;
  localparam logic [3:0] ST_SEG_OFS = 4'd7;
  localparam logic [3:0] ST_CAL_END = 4'd8;
  localparam logic [3:0] ST_CV_MUL  = 4'd9;
  localparam logic [3:0] ST_CV_ADD  = 4'd10;
  localparam logic [3:0] ST_FIN     = 4'd11;

  localparam int P_W = ADC_BITS + VREF_W;
  localparam int X_W = P_W + 4;
  localparam logic [CNT_W-1:0] SPP_CNT = CNT_W'(SAMPLES_PER_POINT);
  localparam logic [DIV_M-1:0] SPP_DIV = DIV_M'(SAMPLES_PER_POINT);
  localparam logic [1:0]       PT_NONE = 2'd3;

  logic [3:0]                state_q, state_d;
  logic [VREF_W-1:0]         vref_q, vref_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [VOLT_W-1:0]         point_v_q [3];
  logic [VOLT_W-1:0]         point_v_d [3];
  logic signed [MUL_A_W-1:0] slope_q [2];
  logic signed [MUL_A_W-1:0] slope_d [2];
  logic signed [MUL_A_W-1:0] ofs_q [2];
  logic signed [MUL_A_W-1:0] ofs_d [2];
  logic [1:0]                inv_q, inv_d;
  logic                      seg_q, seg_d;
  logic                      neg_q, neg_d;
  logic                      out_valid_q, out_valid_d;

  logic [1:0]                pt_q, pt_d;
  logic [ADC_BITS-1:0]       code_q, code_d;
  logic [VOLT_W-1:0]         volt_q, volt_d;
  logic [PH_W-1:0]           res_ph_q, res_ph_d;
  logic                      res_seg_q, res_seg_d;
  logic                      res_done_q, res_done_d;
  logic                      res_derr_q, res_derr_d;
  logic [PH_W-1:0]           out_ph_q, out_ph_d;
  logic                      out_seg_q, out_seg_d;
  logic                      out_done_q, out_done_d;
  logic                      out_derr_q, out_derr_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_P_W-1:0] prod;
  div_req_t                  div_req;
  logic                      div_done;
  logic [DIV_N-1:0]          div_quo;

  logic [P_W-1:0]            p_code;
  logic [X_W-1:0]            x10;
  logic [X_W-1:0]            x_sh;
  logic [VOLT_W-1:0]         sample;
  logic [SUM_W-1:0]          sum_new;
  logic [CNT_W-1:0]          cnt_new;
  logic                      cv_seg;
  logic [VOLT_W-1:0]         v_lo, v_hi;
  logic [VOLT_W:0]           d_seg;
  logic [VOLT_W:0]           d_neg;
  logic [DIV_M-1:0]          d_mag;
  logic signed [MUL_A_W-1:0] prod_hi;
  logic signed [ACC_W-1:0]   ph_sum;
  logic [MUL_A_W-1:0]        q_ext;

  phcc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  phcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // sample scaling: code * vref * 10 >> ADC_BITS, saturated to 16 bits
  assign p_code  = prod[P_W-1:0];
  assign x10     = X_W'({p_code, 3'b000}) + X_W'({p_code, 1'b0});
  assign x_sh    = x10 >> ADC_BITS;
  assign sample  = (x_sh > X_W'(16'hFFFF)) ? 16'hFFFF : x_sh[VOLT_W-1:0];
  assign sum_new = sum_q + SUM_W'(sample);
  assign cnt_new = cnt_q + 1'b1;

  // above the pH 6.86 voltage means the low segment
  assign cv_seg = (volt_q > point_v_q[1]) ? 1'b0 : 1'b1;

  assign v_lo  = seg_q ? point_v_q[1] : point_v_q[0];
  assign v_hi  = seg_q ? point_v_q[2] : point_v_q[1];
  assign d_seg = {1'b0, v_hi} - {1'b0, v_lo};
  assign d_neg = '0 - d_seg;
  assign d_mag = d_seg[VOLT_W] ? d_neg[DIV_M-1:0] : d_seg[DIV_M-1:0];

  // floor of a Q16 product is the arithmetic shift
  assign prod_hi = prod[MUL_P_W-1:16];
  assign ph_sum  = ACC_W'(prod_hi) + ACC_W'(ofs_q[res_seg_q]);
  assign q_ext   = MUL_A_W'(div_quo);

  always_comb begin
    mul_a = slope_q[seg_q];
    mul_b = point_v_q[1];
    case (state_q)
      ST_CAL_MUL: begin
        mul_a = {{(MUL_A_W-ADC_BITS){1'b0}}, code_q};
        mul_b = MUL_B_W'(vref_q);
      end
      ST_CV_MUL: begin
        mul_a = slope_q[cv_seg];
        mul_b = volt_q;
      end
      default: begin
        mul_a = slope_q[seg_q];
        mul_b = point_v_q[1];
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    vref_d      = vref_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    point_v_d   = point_v_q;
    slope_d     = slope_q;
    ofs_d       = ofs_q;
    inv_d       = inv_q;
    seg_d       = seg_q;
    neg_d       = neg_q;
    pt_d        = pt_q;
    code_d      = code_q;
    volt_d      = volt_q;
    res_ph_d    = res_ph_q;
    res_seg_d   = res_seg_q;
    res_done_d  = res_done_q;
    res_derr_d  = res_derr_q;
    out_ph_d    = out_ph_q;
    out_seg_d   = out_seg_q;
    out_done_d  = out_done_q;
    out_derr_d  = out_derr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_req     = '{start: 1'b0, dividend: '0, divisor: SPP_DIV};

    if (cfg_valid_i) begin
      vref_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pt_d       = cal_point_i;
          code_d     = adc_code_i;
          volt_d     = voltage_tenth_mv_i;
          res_ph_d   = '0;
          res_seg_d  = 1'b0;
          res_done_d = 1'b0;
          res_derr_d = 1'b0;
          if (action_i) begin
            state_d = ST_CV_MUL;
          end else if (cal_point_i != PT_NONE) begin
            state_d = ST_CAL_MUL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_CAL_MUL: begin
        state_d = ST_CAL_ACC;
      end
      ST_CAL_ACC: begin
        if (cnt_new >= SPP_CNT) begin
          sum_d   = '0;
          cnt_d   = '0;
          div_req = '{start: 1'b1, dividend: DIV_N'(sum_new), divisor: SPP_DIV};
          state_d = ST_AVG_DIV;
        end else begin
          sum_d   = sum_new;
          cnt_d   = cnt_new;
          state_d = ST_FIN;
        end
      end
      ST_AVG_DIV: begin
        if (div_done) begin
          point_v_d[pt_q] = div_quo[VOLT_W-1:0];
          seg_d           = 1'b0;
          state_d         = ST_SEG_BEG;
        end
      end
      ST_SEG_BEG: begin
        neg_d = d_seg[VOLT_W];
        if (d_seg == '0) begin
          slope_d[seg_q] = '0;
          ofs_d[seg_q]   = '0;
          inv_d[seg_q]   = 1'b1;
          seg_d          = 1'b1;
          state_d        = seg_q ? ST_CAL_END : ST_SEG_BEG;
        end else begin
          div_req = '{start: 1'b1,
                      dividend: seg_q ? SPAN_HIGH_Q16 : SPAN_LOW_Q16,
                      divisor: d_mag};
          state_d = ST_SEG_DIV;
        end
      end
      ST_SEG_DIV: begin
        if (div_done) begin
          slope_d[seg_q] = neg_q ? ('0 - $signed(q_ext)) : $signed(q_ext);
          state_d        = ST_SEG_MUL;
        end
      end
      ST_SEG_MUL: begin
        state_d = ST_SEG_OFS;
      end
      ST_SEG_OFS: begin
        ofs_d[seg_q] = PH_MID_MILLI - prod_hi;
        inv_d[seg_q] = 1'b0;
        seg_d        = 1'b1;
        state_d      = seg_q ? ST_CAL_END : ST_SEG_BEG;
      end
      ST_CAL_END: begin
        res_done_d = 1'b1;
        res_derr_d = inv_q[0] | inv_q[1];
        state_d    = ST_FIN;
      end
      ST_CV_MUL: begin
        res_seg_d = cv_seg;
        if (inv_q[cv_seg]) begin
          res_derr_d = 1'b1;
          state_d    = ST_FIN;
        end else begin
          state_d = ST_CV_ADD;
        end
      end
      ST_CV_ADD: begin
        if (ph_sum < 0) begin
          res_ph_d = '0;
        end else if (ph_sum > PH_MAX_MILLI) begin
          res_ph_d = PH_W'(PH_MAX_MILLI);
        end else begin
          res_ph_d = ph_sum[PH_W-1:0];
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_ph_d    = res_ph_q;
          out_seg_d   = res_seg_q;
          out_done_d  = res_done_q;
          out_derr_d  = res_derr_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vref_q      <= VREF_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      point_v_q   <= '{default: '0};
      slope_q     <= '{default: '0};
      ofs_q       <= '{default: '0};
      inv_q       <= 2'b11;
      seg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vref_q      <= vref_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      point_v_q   <= point_v_d;
      slope_q     <= slope_d;
      ofs_q       <= ofs_d;
      inv_q       <= inv_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    pt_q       <= pt_d;
    code_q     <= code_d;
    volt_q     <= volt_d;
    res_ph_q   <= res_ph_d;
    res_seg_q  <= res_seg_d;
    res_done_q <= res_done_d;
    res_derr_q <= res_derr_d;
    out_ph_q   <= out_ph_d;
    out_seg_q  <= out_seg_d;
    out_done_q <= out_done_d;
    out_derr_q <= out_derr_d;
  end

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign ph_milli_o       = out_ph_q;
  assign segment_used_o   = out_seg_q;
  assign cal_point_done_o = out_done_q;
  assign divide_error_o   = out_derr_q;

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ADC_BITS = 12;
  localparam int SAMPLES  = 50;

  localparam bit ACT_CAL     = 1'b0;
  localparam bit ACT_CONVERT = 1'b1;

  localparam bit [1:0] POINT_PH4   = 2'd0;
  localparam bit [1:0] POINT_PH686 = 2'd1;
  localparam bit [1:0] POINT_PH9   = 2'd2;
  localparam bit [1:0] POINT_NONE  = 2'd3;

  localparam bit SEG_LOW  = 1'b0;
  localparam bit SEG_HIGH = 1'b1;

  localparam longint SPAN_LOW  = 2860;
  localparam longint SPAN_HIGH = 2140;
  localparam longint PH_MID    = 6860;
  localparam longint PH_TOP    = 14000;

  localparam int PHASE_ITEMS  = 125;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    bit        act;
    bit [1:0]  pt;
    bit [11:0] code;
    bit [15:0] volt;
  } probe_req_t;

  typedef struct packed {
    bit [13:0] ph;
    bit        seg;
    bit        done;
    bit        derr;
  } ph_result_t;

  typedef struct packed {
    probe_req_t req;
    ph_result_t res;
  } table_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [phcc_pkg::VREF_W-1:0]   cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          action_i;
  logic [1:0]                    cal_point_i;
  logic [ADC_BITS-1:0]           adc_code_i;
  logic [phcc_pkg::VOLT_W-1:0]   voltage_tenth_mv_i;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [phcc_pkg::PH_W-1:0]     ph_milli_o;
  logic                          segment_used_o;
  logic                          cal_point_done_o;
  logic                          divide_error_o;

  ph_three_point_calibrated_converter_unit #(
    .ADC_BITS         (ADC_BITS),
    .SAMPLES_PER_POINT(SAMPLES)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .cal_point_i       (cal_point_i),
    .adc_code_i        (adc_code_i),
    .voltage_tenth_mv_i(voltage_tenth_mv_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .ph_milli_o        (ph_milli_o),
    .segment_used_o    (segment_used_o),
    .cal_point_done_o  (cal_point_done_o),
    .divide_error_o    (divide_error_o)
  );

  // calibration state mirrored from the unit
  logic [phcc_pkg::VREF_W-1:0] vref_mv = phcc_pkg::VREF_RESET;
  logic [21:0]                 acc_sum = '0;
  logic [5:0]                  acc_count = '0;
  logic [15:0]                 point_mv [3] = '{16'd0, 16'd0, 16'd0};
  int                          seg_slope [2] = '{0, 0};
  int                          seg_offset [2] = '{0, 0};
  bit                          seg_bad [2] = '{1'b1, 1'b1};
  bit                          point_finished = 1'b0;

  ph_result_t ph_due_q [$];
  ph_result_t want_r;
  int         fail_count = 0;
  int         item_count = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         last_base [3] = '{0, 0, 0};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ph_due_q.size() == 0) begin
        $error("result with no request pending: ph_milli %0d", ph_milli_o);
        fail_count++;
      end else begin
        want_r = ph_due_q.pop_front();
        if (ph_milli_o !== want_r.ph) begin
          $error("ph_milli: expected %0d, actual %0d", want_r.ph, ph_milli_o);
          fail_count++;
        end
        if (segment_used_o !== want_r.seg) begin
          $error("segment_used: expected %0d, actual %0d", want_r.seg, segment_used_o);
          fail_count++;
        end
        if (cal_point_done_o !== want_r.done) begin
          $error("cal_point_done: expected %0d, actual %0d", want_r.done, cal_point_done_o);
          fail_count++;
        end
        if (divide_error_o !== want_r.derr) begin
          $error("divide_error: expected %0d, actual %0d", want_r.derr, divide_error_o);
          fail_count++;
        end
      end
    end
  end

  function automatic void fit_segment(input bit s, input longint lo, input longint hi,
                                      input longint span);
    longint d;
    longint q;
    d = hi - lo;
    if (d == 0) begin
      seg_slope[s]  = 0;
      seg_offset[s] = 0;
      seg_bad[s]    = 1'b1;
    end else begin
      q = (span * 65536) / ((d < 0) ? -d : d);
      if (d < 0) q = -q;
      seg_slope[s] = int'(q);
      // arithmetic shift gives the floor for negative products
      seg_offset[s] = int'(PH_MID - ((q * longint'(point_mv[POINT_PH686])) >>> 16));
      seg_bad[s] = 1'b0;
    end
  endfunction

  function automatic ph_result_t predict_ph(input probe_req_t r);
    ph_result_t res;
    longint     smp;
    longint     v;
    longint     acc;
    bit         sel;
    res = '0;
    point_finished = 1'b0;
    if (r.act == ACT_CAL) begin
      if (r.pt != POINT_NONE) begin
        smp = (longint'(r.code) * longint'(vref_mv) * 10) >>> ADC_BITS;
        if (smp > 65535) smp = 65535;
        acc_sum   = acc_sum + smp[21:0];
        acc_count = acc_count + 6'd1;
        if (acc_count >= SAMPLES) begin
          point_mv[r.pt] = 16'(acc_sum / SAMPLES);
          acc_sum   = '0;
          acc_count = '0;
          fit_segment(SEG_LOW, point_mv[POINT_PH4], point_mv[POINT_PH686], SPAN_LOW);
          fit_segment(SEG_HIGH, point_mv[POINT_PH686], point_mv[POINT_PH9], SPAN_HIGH);
          res.done = 1'b1;
          res.derr = seg_bad[SEG_LOW] | seg_bad[SEG_HIGH];
          point_finished = 1'b1;
        end
      end
    end else begin
      sel = (r.volt > point_mv[POINT_PH686]) ? SEG_LOW : SEG_HIGH;
      res.seg = sel;
      if (seg_bad[sel]) begin
        res.derr = 1'b1;
      end else begin
        v = r.volt;
        acc = ((longint'(seg_slope[sel]) * v) >>> 16) + longint'(seg_offset[sel]);
        if (acc < 0) acc = 0;
        if (acc > PH_TOP) acc = PH_TOP;
        res.ph = acc[13:0];
      end
    end
    return res;
  endfunction

  function automatic table_row_t row(input bit act, input bit [1:0] pt, input bit [11:0] code,
                                     input bit [15:0] volt, input bit [13:0] ph,
                                     input bit seg, input bit done, input bit derr);
    table_row_t t;
    t.req = '{act: act, pt: pt, code: code, volt: volt};
    t.res = '{ph: ph, seg: seg, done: done, derr: derr};
    return t;
  endfunction

  // valid is only lowered when a gap follows, so it never drops and rises in one step
  task automatic send_req(input probe_req_t r, input bit typed, input ph_result_t typed_res);
    ph_result_t res;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i         <= 1'b1;
    action_i           <= r.act;
    cal_point_i        <= r.pt;
    adc_code_i         <= r.code;
    voltage_tenth_mv_i <= r.volt;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_ph(r);
    ph_due_q.push_back(typed ? typed_res : res);
    if (!(r.act == ACT_CAL && r.pt == POINT_NONE)) item_count++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (ph_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic bit [15:0] pick_volt();
    longint v;
    int     off;
    off = int'($urandom_range(0, 200)) - 100;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 65535);
      1: v = point_mv[POINT_PH686];
      2: v = longint'(point_mv[POINT_PH686]) + 1;
      3: v = longint'(point_mv[POINT_PH686]) - 1;
      4: v = longint'(point_mv[POINT_PH4]) + off;
      5: v = longint'(point_mv[POINT_PH9]) + off;
      6: v = $urandom_range(0, 1) ? 0 : 65535;
      default: v = $urandom_range(0, 50000);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // one point's worth of samples, sprinkled with converts and stray requests
  task automatic cal_session(input bit [1:0] pt);
    int         base;
    int         jit;
    int         code;
    int         n;
    probe_req_t r;
    if ($urandom_range(0, 7) == 0) begin
      // same code as another point, so the two averages tend to match
      base = last_base[(pt + $urandom_range(1, 2)) % 3];
      jit  = 0;
    end else begin
      case ($urandom_range(0, 7))
        0: base = 0;
        1: base = 4095;
        default: base = $urandom_range(0, 4095);
      endcase
      jit = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
    end
    last_base[pt] = base;
    do begin
      n = $urandom_range(0, 99);
      code = base + int'($urandom_range(0, 2 * jit)) - jit;
      if (code < 0) code = 0;
      if (code > 4095) code = 4095;
      r.act  = ACT_CAL;
      r.pt   = pt;
      r.code = 12'(code);
      r.volt = 16'($urandom);
      if (n < 6) begin
        r.act  = ACT_CONVERT;
        r.volt = pick_volt();
      end else if (n < 9) begin
        r.pt = POINT_NONE;
      end else if (n < 12) begin
        r.pt = 2'($urandom_range(0, 2));
      end
      send_req(r, 1'b0, '0);
    end while (!point_finished);
  endtask

  initial begin
    table_row_t                  dir_tab [$];
    probe_req_t                  r;
    logic [phcc_pkg::VREF_W-1:0] vref_next;
    int                          phase_start;
    bit [1:0]                    next_pt;
    int                          phase_idle [4];
    int                          phase_stall [4];

    phase_idle  = '{0, 65, 0, 29};
    phase_stall = '{0, 0, 65, 29};
    next_pt     = POINT_PH9;

    rst_ni             <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_data_i         <= '0;
    in_valid_i         <= 1'b0;
    action_i           <= ACT_CAL;
    cal_point_i        <= POINT_PH4;
    adc_code_i         <= '0;
    voltage_tenth_mv_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing calibrated yet: converts flag the segment, samples answer zeros
    dir_tab.push_back(row(ACT_CONVERT, POINT_PH4,   12'h000, 16'd0,     0, SEG_HIGH, 0, 1));
    dir_tab.push_back(row(ACT_CONVERT, POINT_PH4,   12'h000, 16'd1,     0, SEG_LOW,  0, 1));
    dir_tab.push_back(row(ACT_CONVERT, POINT_PH686, 12'h000, 16'hFFFF,  0, SEG_LOW,  0, 1));
    dir_tab.push_back(row(ACT_CONVERT, POINT_PH9,   12'h000, 16'd50000, 0, SEG_LOW,  0, 1));
    dir_tab.push_back(row(ACT_CONVERT, POINT_NONE,  12'hFFF, 16'h5555,  0, SEG_LOW,  0, 1));
    dir_tab.push_back(row(ACT_CONVERT, POINT_PH4,   12'hAAA, 16'hAAAA,  0, SEG_LOW,  0, 1));
    dir_tab.push_back(row(ACT_CAL,     POINT_PH4,   12'h000, 16'hFFFF,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CAL,     POINT_PH686, 12'hFFF, 16'h0000,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CAL,     POINT_PH9,   12'hAAA, 16'h5555,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CAL,     POINT_NONE,  12'hFFF, 16'hFFFF,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CAL,     POINT_NONE,  12'h000, 16'h0000,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CAL,     POINT_PH4,   12'h555, 16'hAAAA,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CONVERT, POINT_PH686, 12'hFFF, 16'h8000,  0, SEG_LOW,  0, 1));
    dir_tab.push_back(row(ACT_CAL,     POINT_PH686, 12'h001, 16'h7FFF,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CAL,     POINT_PH9,   12'h800, 16'h0001,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CONVERT, POINT_PH9,   12'h555, 16'h7FFF,  0, SEG_LOW,  0, 1));
    dir_tab.push_back(row(ACT_CAL,     POINT_PH4,   12'h800, 16'h8000,  0, SEG_LOW,  0, 0));
    dir_tab.push_back(row(ACT_CONVERT, POINT_NONE,  12'h000, 16'd2,     0, SEG_LOW,  0, 1));

    foreach (dir_tab[i]) send_req(dir_tab[i].req, 1'b1, dir_tab[i].res);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      case (ph)
        0: vref_next = 13'd5000;
        1: vref_next = 13'd8191;
        2: vref_next = 13'd1;
        default: vref_next = 13'($urandom_range(1, 8191));
      endcase
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= vref_next;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      vref_mv = vref_next;

      phase_start = item_count;
      while (item_count - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) next_pt = 2'($urandom_range(0, 2));
        else next_pt = (next_pt == POINT_PH9) ? POINT_PH4 : next_pt + 2'd1;
        cal_session(next_pt);
        repeat ($urandom_range(4, 12)) begin
          r.act  = ACT_CONVERT;
          r.pt   = 2'($urandom_range(0, 3));
          r.code = 12'($urandom);
          r.volt = pick_volt();
          send_req(r, 1'b0, '0);
        end
      end
      drain();
    end

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
rtl/phcc_pkg.sv
rtl/phcc_mul.sv
rtl/phcc_div.sv
rtl/ph_three_point_calibrated_converter_unit.sv
bench/testbench.sv
